### rtl/core/sips_pkg.sv
// sorted insert position search: shared types and constants
// item and result beats, sequencer states and index type
// no dependencies
`default_nettype none

package sips_pkg;

    localparam int DATA_W          = 32;
    localparam int SIZE_W          = 11;
    localparam int SLOT_W          = 10;
    localparam int IDX_W           = SIZE_W + 1;
    localparam int DEF_TABLE_DEPTH = 1024;

    typedef enum logic {
        FUNC_WRITE  = 1'b0,
        FUNC_SEARCH = 1'b1
    } t_func;

    typedef struct packed {
        t_func                     func;
        logic [SLOT_W-1:0]         slot;
        logic signed [DATA_W-1:0]  entry_value;
        logic signed [DATA_W-1:0]  search_key;
    } t_in_item;

    typedef struct packed {
        logic [SIZE_W-1:0] position;
        logic              found;
    } t_out_item;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_PROBE,
        ST_WAIT
    } t_state;

    typedef logic signed [IDX_W-1:0] t_idx;

endpackage

`default_nettype wire

### rtl/core/sorted_insert_position_search.sv
// sorted insert position search top level: config register, write path, sequencer, table
// write beat: busy stays low, next beat accepted the following cycle
// search beat: busy holds off new beats until the search ends, result strobe rises as busy falls
// k probes, k <= floor(log2(n))+1, one read plus one compare each
// results cannot be stalled; sync reset clears table size to 0 and the sequencer, not the table
// depends on sips_pkg, sips_ctrl, sips_mem
`default_nettype none

module sorted_insert_position_search
    import sips_pkg::*;
#(
    parameter int TABLE_DEPTH = DEF_TABLE_DEPTH
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_cfg_valid,
    output logic                   o_cfg_ready,
    input  wire logic [SIZE_W-1:0] i_cfg_data,
    input  wire logic              start,
    output logic                   busy,
    input  wire t_in_item          i_in,
    output logic                   o_res_valid,
    output t_out_item              o_res
);

    localparam int AW = $clog2(TABLE_DEPTH);

    logic [SIZE_W-1:0]        r_table_size;
    logic [IDX_W-1:0]         w_count;
    logic                     w_accept;
    logic                     w_wr_en;
    logic                     w_go;
    logic                     w_rd_en;
    logic [AW-1:0]            w_rd_addr;
    logic signed [DATA_W-1:0] w_rd_data;

    assign o_cfg_ready = !busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_table_size <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_table_size <= i_cfg_data;
        end
    end

    assign w_count = (32'(r_table_size) > TABLE_DEPTH) ? IDX_W'(TABLE_DEPTH)
                                                        : {1'b0, r_table_size};

    assign w_accept = start && !busy;
    assign w_wr_en  = w_accept && (i_in.func == FUNC_WRITE) && (32'(i_in.slot) < TABLE_DEPTH);
    assign w_go     = w_accept && (i_in.func == FUNC_SEARCH);

    sips_mem #(
        .DEPTH     (TABLE_DEPTH)
    ) u_mem (
        .i_clk     (i_clk),
        .i_wr_en   (w_wr_en),
        .i_wr_addr (AW'(i_in.slot)),
        .i_wr_data (i_in.entry_value),
        .i_rd_en   (w_rd_en),
        .i_rd_addr (w_rd_addr),
        .o_rd_data (w_rd_data)
    );

    sips_ctrl #(
        .DEPTH       (TABLE_DEPTH)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_go        (w_go),
        .i_key       (i_in.search_key),
        .i_count     (w_count),
        .o_busy      (busy),
        .o_rd_en     (w_rd_en),
        .o_rd_addr   (w_rd_addr),
        .i_rd_data   (w_rd_data),
        .o_res_valid (o_res_valid),
        .o_res       (o_res)
    );

endmodule

`default_nettype wire

### rtl/core/sips_mem.sv
// sorted insert position search: table storage
// single port write, registered read
// depends on sips_pkg
`default_nettype none

module sips_mem
    import sips_pkg::*;
#(
    parameter int  DEPTH = DEF_TABLE_DEPTH,
    localparam int AW    = $clog2(DEPTH)
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_wr_en,
    input  wire logic [AW-1:0]            i_wr_addr,
    input  wire logic signed [DATA_W-1:0] i_wr_data,
    input  wire logic                     i_rd_en,
    input  wire logic [AW-1:0]            i_rd_addr,
    output logic signed [DATA_W-1:0]      o_rd_data
);

    logic signed [DATA_W-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            o_rd_data <= r_mem[i_rd_addr];
        end
    end

endmodule

`default_nettype wire

### rtl/core/sips_ctrl.sv
// sorted insert position search: binary search sequencer
// issues one table read per probe, compares and narrows the bounds
// depends on sips_pkg
`default_nettype none

module sips_ctrl
    import sips_pkg::*;
#(
    parameter int  DEPTH = DEF_TABLE_DEPTH,
    localparam int AW    = $clog2(DEPTH)
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     i_go,
    input  wire logic signed [DATA_W-1:0] i_key,
    input  wire logic [IDX_W-1:0]         i_count,
    output logic                          o_busy,
    output logic                          o_rd_en,
    output logic [AW-1:0]                 o_rd_addr,
    input  wire logic signed [DATA_W-1:0] i_rd_data,
    output logic                          o_res_valid,
    output t_out_item                     o_res
);

    t_state                   r_state, n_state;
    t_idx                     r_lo, n_lo;
    t_idx                     r_hi, n_hi;
    logic [SIZE_W-1:0]        r_mid, n_mid;
    logic signed [DATA_W-1:0] r_key, n_key;
    logic                     r_res_valid, n_res_valid;
    t_out_item                r_res, n_res;

    logic [IDX_W:0]           w_sum;
    logic [SIZE_W-1:0]        w_mid;

    assign w_sum = (IDX_W + 1)'(r_lo) + (IDX_W + 1)'(r_hi);
    assign w_mid = w_sum[SIZE_W:1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_res_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_res_valid <= n_res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_lo  <= n_lo;
        r_hi  <= n_hi;
        r_mid <= n_mid;
        r_key <= n_key;
        r_res <= n_res;
    end

    always_comb begin
        n_state     = r_state;
        n_lo        = r_lo;
        n_hi        = r_hi;
        n_mid       = r_mid;
        n_key       = r_key;
        n_res_valid = 1'b0;
        n_res       = r_res;
        o_rd_en     = 1'b0;
        o_rd_addr   = AW'(w_mid);
        unique case (r_state)
            ST_IDLE: begin
                if (i_go) begin
                    n_lo    = '0;
                    n_hi    = $signed(i_count) - t_idx'(1);
                    n_key   = i_key;
                    n_state = ST_PROBE;
                end
            end
            ST_PROBE: begin
                if (r_lo <= r_hi) begin
                    o_rd_en = 1'b1;
                    n_mid   = w_mid;
                    n_state = ST_WAIT;
                end else begin
                    n_res.position = r_lo[SIZE_W-1:0];
                    n_res.found    = 1'b0;
                    n_res_valid    = 1'b1;
                    n_state        = ST_IDLE;
                end
            end
            ST_WAIT: begin
                if (r_key > i_rd_data) begin
                    n_lo    = $signed({1'b0, r_mid}) + t_idx'(1);
                    n_state = ST_PROBE;
                end else if (r_key < i_rd_data) begin
                    n_hi    = $signed({1'b0, r_mid}) - t_idx'(1);
                    n_state = ST_PROBE;
                end else begin
                    n_res.position = r_mid;
                    n_res.found    = 1'b1;
                    n_res_valid    = 1'b1;
                    n_state        = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign o_busy      = (r_state != ST_IDLE);
    assign o_res_valid = r_res_valid;
    assign o_res       = r_res;

`ifndef SYNTHESIS
    a_bounds_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_PROBE) |-> (r_lo <= r_hi + t_idx'(1)))
        else $error("search bounds crossed by more than one");

    a_wait_after_probe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_WAIT) |-> ($past(r_state) == ST_PROBE))
        else $error("compare cycle without a read");

    a_strobe_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_res_valid |-> ($past(r_state) == ST_PROBE || $past(r_state) == ST_WAIT))
        else $error("result strobe outside a search");

    a_strobe_ends_search: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_res_valid |-> (r_state == ST_IDLE))
        else $error("result strobe while search still running");
`endif

endmodule

`default_nettype wire

### test/sorted_insert_position_search_tb.sv
// testbench for sorted_insert_position_search: table loads, size changes and key lookups
// directed stimulus table, then randomized sorted loads and searches checked by a local predictor
// depends on sips_pkg and the sorted_insert_position_search rtl
`default_nettype none

module sorted_insert_position_search_tb
    import sips_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int TABLE_DEPTH   = DEF_TABLE_DEPTH;
    localparam int ITEM_TARGET   = 1750;
    localparam int CYCLE_LIMIT   = 600000;
    localparam int SETTLE_CYCLES = 30;
    localparam int CFG_PAUSE     = 4;
    localparam int SIZE_FIELD_MAX = (1 << SIZE_W) - 1;

    localparam logic signed [DATA_W-1:0] VAL_MAX = 32'sh7fff_ffff;
    localparam logic signed [DATA_W-1:0] VAL_MIN = 32'sh8000_0000;

    typedef enum bit {
        ROW_CFG,
        ROW_BEAT
    } t_row_kind;

    typedef struct {
        t_row_kind         kind;
        logic [SIZE_W-1:0] size;
        t_in_item          beat;
        bit                typed;
        t_out_item         want;
    } t_dir_row;

    logic              i_clk;
    logic              i_rst_n;
    logic              i_cfg_valid;
    logic              o_cfg_ready;
    logic [SIZE_W-1:0] i_cfg_data;
    logic              start;
    logic              busy;
    t_in_item          i_in;
    logic              o_res_valid;
    t_out_item         o_res;

    bit signed [DATA_W-1:0] shadow_tbl [TABLE_DEPTH];
    logic [SIZE_W-1:0]      shadow_size;
    t_out_item              pending_lookups [$];
    t_dir_row               dir_rows [$];

    int unsigned beats_sent;
    int unsigned errors;
    int unsigned cycle_count;
    int          burst_left;
    bit          gaps_on;

    sorted_insert_position_search #(
        .TABLE_DEPTH(TABLE_DEPTH)
    ) uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_valid(i_cfg_valid),
        .o_cfg_ready(o_cfg_ready),
        .i_cfg_data (i_cfg_data),
        .start      (start),
        .busy       (busy),
        .i_in       (i_in),
        .o_res_valid(o_res_valid),
        .o_res      (o_res)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("[sorted_insert_position_search] ERROR");
            $finish;
        end
    end

    task automatic report_mismatch(input string msg);
        $display("[%0t] mismatch: %s", $realtime, msg);
        errors++;
    endtask

    always @(posedge i_clk) begin : check_results
        t_out_item want;
        if (i_rst_n && o_res_valid) begin
            if (pending_lookups.size() == 0) begin
                report_mismatch("result beat with no lookup pending");
            end else begin
                want = pending_lookups.pop_front();
                if (o_res.position !== want.position)
                    report_mismatch($sformatf("position got %0d want %0d",
                                              o_res.position, want.position));
                if (o_res.found !== want.found)
                    report_mismatch($sformatf("found got %0b want %0b",
                                              o_res.found, want.found));
            end
        end
    end

    // binary search over the shadow table, midpoint rounded down, first hit wins
    function automatic t_out_item locate(input logic signed [DATA_W-1:0] key);
        int        lo;
        int        hi;
        int        mid;
        int        n;
        bit        hit;
        t_out_item r;
        n   = (int'(shadow_size) > TABLE_DEPTH) ? TABLE_DEPTH : int'(shadow_size);
        lo  = 0;
        hi  = n - 1;
        hit = 1'b0;
        r   = '0;
        while (!hit && lo <= hi) begin
            mid = (lo + hi) / 2;
            if (key > shadow_tbl[mid]) begin
                lo = mid + 1;
            end else if (key < shadow_tbl[mid]) begin
                hi = mid - 1;
            end else begin
                hit = 1'b1;
                r.position = SIZE_W'(mid);
            end
        end
        if (!hit)
            r.position = SIZE_W'(lo);
        r.found = hit;
        return r;
    endfunction

    function automatic logic signed [DATA_W-1:0] clamp32(input longint v);
        if (v > longint'(VAL_MAX))
            return VAL_MAX;
        if (v < longint'(VAL_MIN))
            return VAL_MIN;
        return v[DATA_W-1:0];
    endfunction

    function automatic t_in_item build_write_beat(input int slot,
                                                  input logic signed [DATA_W-1:0] val);
        t_in_item it;
        it.func        = FUNC_WRITE;
        it.slot        = SLOT_W'(slot);
        it.entry_value = val;
        it.search_key  = $urandom;
        return it;
    endfunction

    function automatic t_in_item build_search_beat(input logic signed [DATA_W-1:0] key);
        t_in_item it;
        it.func        = FUNC_SEARCH;
        it.slot        = SLOT_W'($urandom);
        it.entry_value = $urandom;
        it.search_key  = key;
        return it;
    endfunction

    function automatic void add_cfg(input int size);
        t_dir_row row;
        row.kind  = ROW_CFG;
        row.size  = SIZE_W'(size);
        row.beat  = '0;
        row.typed = 1'b0;
        row.want  = '0;
        dir_rows  = {dir_rows, row};
    endfunction

    function automatic void add_write(input int slot, input logic signed [DATA_W-1:0] val);
        t_dir_row row;
        row.kind  = ROW_BEAT;
        row.size  = '0;
        row.beat  = build_write_beat(slot, val);
        row.typed = 1'b0;
        row.want  = '0;
        dir_rows  = {dir_rows, row};
    endfunction

    function automatic void add_search(input logic signed [DATA_W-1:0] key, input bit typed,
                                       input int pos, input bit fnd);
        t_dir_row row;
        row.kind          = ROW_BEAT;
        row.size          = '0;
        row.beat          = build_search_beat(key);
        row.typed         = typed;
        row.want.position = SIZE_W'(pos);
        row.want.found    = fnd;
        dir_rows          = {dir_rows, row};
    endfunction

    // sender bursts, start dropped for a random gap between bursts when gaps_on is set
    task automatic put_beat(input t_in_item it, input bit typed, input t_out_item want);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            if (gaps_on) begin
                gap = $urandom_range(1, 10);
                @(negedge i_clk);
                start = 1'b0;
                repeat (gap - 1) @(negedge i_clk);
            end
        end
        burst_left--;
        @(negedge i_clk);
        start = 1'b1;
        i_in  = it;
        do @(posedge i_clk); while (busy);
        beats_sent++;
        if (it.func == FUNC_WRITE)
            shadow_tbl[it.slot] = it.entry_value;
        else
            pending_lookups = {pending_lookups, (typed ? want : locate(it.search_key))};
    endtask

    task automatic set_table_size(input int size);
        @(negedge i_clk);
        start = 1'b0;
        while (pending_lookups.size() != 0 || busy) @(negedge i_clk);
        repeat (CFG_PAUSE) @(negedge i_clk);
        i_cfg_valid = 1'b1;
        i_cfg_data  = SIZE_W'(size);
        do @(posedge i_clk); while (!o_cfg_ready);
        shadow_size = SIZE_W'(size);
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    // ascending content: wide spread, dense with duplicates, or pinned to the extremes
    task automatic load_sorted(input int n);
        longint                 cur;
        longint                 span;
        int                     mode;
        logic signed [DATA_W-1:0] v;
        mode = $urandom_range(0, 2);
        span = 64'sh1_0000_0000 / (n + 1);
        if (mode == 1)
            cur = longint'($signed($urandom));
        else
            cur = longint'(VAL_MIN) + longint'($urandom) % (span + 1);
        for (int i = 0; i < n; i++) begin
            v = clamp32(cur);
            if (mode == 2 && i == 0)
                v = VAL_MIN;
            if (mode == 2 && i == n - 1 && n > 1)
                v = VAL_MAX;
            put_beat(build_write_beat(i, v), 1'b0, '0);
            if (mode == 1)
                cur += longint'($urandom_range(0, 2));
            else
                cur += longint'($urandom) % (2 * span + 1);
        end
    endtask

    function automatic logic signed [DATA_W-1:0] pick_key(input int n);
        longint k;
        int     idx;
        idx = (n > 0) ? $urandom_range(0, n - 1) : 0;
        case ($urandom_range(0, 5))
            0, 1: k = longint'(shadow_tbl[idx]);
            2: k = longint'(shadow_tbl[idx]) + 1;
            3: k = longint'(shadow_tbl[idx]) - 1;
            4: k = $urandom_range(0, 1) ? longint'(VAL_MAX) : longint'(VAL_MIN);
            default: k = longint'($signed($urandom));
        endcase
        return clamp32(k);
    endfunction

    task automatic run_searches(input int count, input int n);
        repeat (count) put_beat(build_search_beat(pick_key(n)), 1'b0, '0);
    endtask

    initial begin
        int n;
        i_rst_n     = 1'b0;
        i_cfg_valid = 1'b0;
        i_cfg_data  = '0;
        start       = 1'b0;
        i_in        = '0;
        shadow_size = '0;
        beats_sent  = 0;
        errors      = 0;
        cycle_count = 0;
        burst_left  = 0;
        gaps_on     = 1'b1;

        // empty table, then four and one entry tables starting at the minimum value
        add_cfg(0);
        add_search(32'sd0, 1'b1, 0, 1'b0);
        add_search(VAL_MAX, 1'b1, 0, 1'b0);
        add_search(VAL_MIN, 1'b1, 0, 1'b0);
        add_write(0, VAL_MIN);
        add_write(1, -32'sd5);
        add_write(2, 32'sd0);
        add_write(3, 32'sd7);
        add_write(TABLE_DEPTH - 1, VAL_MAX);
        add_cfg(4);
        add_search(VAL_MIN, 1'b1, 0, 1'b1);
        add_search(VAL_MAX, 1'b1, 4, 1'b0);
        add_search(32'sd7, 1'b0, 0, 1'b0);
        add_search(-32'sd5, 1'b1, 1, 1'b1);
        add_search(32'sd1, 1'b0, 0, 1'b0);
        add_search(-32'sd6, 1'b0, 0, 1'b0);
        add_cfg(1);
        add_search(VAL_MIN, 1'b1, 0, 1'b1);
        add_search(32'sd0, 1'b1, 1, 1'b0);
        // unsorted content
        add_write(1, 32'sd100);
        add_cfg(4);
        add_search(-32'sd5, 1'b0, 0, 1'b0);
        add_search(32'sd100, 1'b0, 0, 1'b0);

        repeat (10) @(negedge i_clk);
        i_rst_n = 1'b1;

        foreach (dir_rows[r]) begin
            if (dir_rows[r].kind == ROW_CFG)
                set_table_size(dir_rows[r].size);
            else
                put_beat(dir_rows[r].beat, dir_rows[r].typed, dir_rows[r].want);
        end

        // full table first, so every later size only reads written entries
        load_sorted(TABLE_DEPTH);
        set_table_size(TABLE_DEPTH);
        run_searches(40, TABLE_DEPTH);
        set_table_size(SIZE_FIELD_MAX);
        run_searches(20, TABLE_DEPTH);
        set_table_size($urandom_range(TABLE_DEPTH + 1, SIZE_FIELD_MAX - 1));
        run_searches(10, TABLE_DEPTH);

        while (beats_sent < ITEM_TARGET) begin
            gaps_on = ($urandom_range(0, 3) != 0);
            case ($urandom_range(0, 9))
                0: begin
                    set_table_size(0);
                    run_searches(6, 0);
                end
                1: begin
                    n = $urandom_range(41, TABLE_DEPTH);
                    set_table_size(n);
                    run_searches(12, n);
                end
                default: begin
                    n = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 2)
                                                    : $urandom_range(1, 40);
                    load_sorted(n);
                    if ($urandom_range(0, 5) == 0)
                        repeat ($urandom_range(1, 3))
                            put_beat(build_write_beat($urandom_range(0, n - 1), $urandom),
                                     1'b0, '0);
                    set_table_size(n);
                    run_searches(n + 8, n);
                end
            endcase
        end

        @(negedge i_clk);
        start = 1'b0;
        while (pending_lookups.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (errors == 0 && pending_lookups.size() == 0)
            $display("[sorted_insert_position_search] OK");
        else
            $display("[sorted_insert_position_search] ERROR");
        $finish;
    end

endmodule

`default_nettype wire
